@@ sv/skht_pkg.sv @@
package skht_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = 9;
  localparam int UNIT_W      = SIZE_W + 1;
  localparam int HASH_W      = 64;
  localparam int BIT_CNT_W   = $clog2(HASH_W);

  localparam logic [HASH_W-1:0] HASH_SEED  = 64'd5381;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_RD,
    S_CMP
  } state_t;

  typedef struct packed {
    logic              en;
    logic              used;
    logic [ADDR_W-1:0] addr;
    logic [HASH_W-1:0] hash;
  } tbl_wr_t;

endpackage

@@ sv/skht_table.sv @@
module skht_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [skht_pkg::ADDR_W-1:0]   rd_addr,
  input  skht_pkg::tbl_wr_t             wr,
  output logic [skht_pkg::HASH_W-1:0]   rd_hash,
  output logic                          rd_used
);

  logic [skht_pkg::HASH_W-1:0] slot_hash_mem [skht_pkg::TABLE_DEPTH];
  logic [skht_pkg::TABLE_DEPTH-1:0] slot_used_r;
  logic [skht_pkg::HASH_W-1:0] rd_hash_r;
  logic rd_used_r;

  // unused slots read as hash zero
  always_ff @(posedge clk) begin
    if (wr.en && wr.used) begin
      slot_hash_mem[wr.addr] <= wr.hash;
    end
    if (rd_en) begin
      rd_hash_r <= slot_hash_mem[rd_addr];
      rd_used_r <= slot_used_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_used_r <= '0;
    end else if (wr.en) begin
      slot_used_r[wr.addr] <= wr.used;
    end
  end

  assign rd_used = rd_used_r;
  assign rd_hash = rd_used_r ? rd_hash_r : '0;

endmodule

@@ sv/string_keyed_hash_table_top.sv @@
// Key bytes: one item per cycle while idle, busy stays low, no result.
// Last byte with op 3: result strobe in the following cycle.
// Last byte otherwise: remainder of the 64-bit hash by the size in use (one bit a cycle
// through the shared subtract/compare unit), then per probe a table read and a compare;
// result strobe after the last of p probes, p at most the size in use.
// Reset: empty table, size 256, hash seed 5381; no result is ever stalled.
module string_keyed_hash_table_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_op,
  input  logic [7:0]                    in_key_byte,
  input  logic                          in_byte_valid,
  input  logic                          in_last,
  output logic                          out_valid,
  output logic                          out_ok,
  output logic [7:0]                    out_slot,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [skht_pkg::SIZE_W-1:0]   cfg_data
);

  localparam int AW = skht_pkg::ADDR_W;
  localparam int SW = skht_pkg::SIZE_W;
  localparam int UW = skht_pkg::UNIT_W;
  localparam int HW = skht_pkg::HASH_W;
  localparam int BW = skht_pkg::BIT_CNT_W;

  skht_pkg::state_t state_r, state_nxt;
  logic [SW-1:0] cfg_size_r;
  logic [SW-1:0] size_eff;
  logic [SW-1:0] size_r, size_nxt;
  logic [HW-1:0] hash_r, hash_nxt;
  logic [HW-1:0] key_r, key_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [HW-1:0] div_sh_r, div_sh_nxt;
  logic [BW-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] step_r, step_nxt;
  logic [SW-1:0] probe_cnt_r, probe_cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_ok_r, out_ok_nxt;
  logic [7:0]    out_slot_r, out_slot_nxt;

  logic [HW-1:0] hash_in;
  logic [HW-1:0] byte_ext;
  logic [UW-1:0] unit_a;
  logic [UW-1:0] unit_res;
  logic          hit;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [HW-1:0]     rd_hash;
  logic              rd_used;
  skht_pkg::tbl_wr_t wr;

  skht_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd_hash (rd_hash),
    .rd_used (rd_used)
  );

  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_size_r == '0) begin
      size_eff = SW'(1);
    end else if (cfg_size_r > SW'(skht_pkg::TABLE_DEPTH)) begin
      size_eff = SW'(skht_pkg::TABLE_DEPTH);
    end else begin
      size_eff = cfg_size_r;
    end
  end

  // djb2 fold; a zero byte is skipped
  assign byte_ext = {{(HW-8){in_key_byte[7]}}, in_key_byte};
  assign hash_in  = (in_byte_valid && in_key_byte != 8'd0)
                    ? (hash_r << 5) + hash_r + byte_ext : hash_r;

  // shared conditional subtract of the modulus
  assign unit_res = (unit_a >= UW'(size_r)) ? unit_a - UW'(size_r) : unit_a;

  assign hit = ((op_r == skht_pkg::OP_ADD) && !rd_used) || (rd_hash == key_r);

  always_comb begin
    state_nxt     = state_r;
    size_nxt      = size_r;
    hash_nxt      = hash_r;
    key_nxt       = key_r;
    op_nxt        = op_r;
    rem_nxt       = rem_r;
    div_sh_nxt    = div_sh_r;
    bit_cnt_nxt   = bit_cnt_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    probe_cnt_nxt = probe_cnt_r;
    out_valid_nxt = 1'b0;
    out_ok_nxt    = out_ok_r;
    out_slot_nxt  = out_slot_r;
    unit_a        = '0;
    rd_en         = 1'b0;
    rd_addr       = idx_r;
    wr            = '0;
    unique case (state_r)
      skht_pkg::S_IDLE: begin
        if (start) begin
          hash_nxt = hash_in;
          if (in_last) begin
            hash_nxt    = skht_pkg::HASH_SEED;
            key_nxt     = hash_in;
            op_nxt      = in_op;
            size_nxt    = size_eff;
            rem_nxt     = '0;
            div_sh_nxt  = hash_in;
            bit_cnt_nxt = '1;
            if (in_op == skht_pkg::OP_NONE) begin
              out_valid_nxt = 1'b1;
              out_ok_nxt    = 1'b0;
              out_slot_nxt  = 8'd0;
            end else begin
              state_nxt = skht_pkg::S_DIV;
            end
          end
        end
      end
      skht_pkg::S_DIV: begin
        unit_a      = {rem_r, div_sh_r[HW-1]};
        rem_nxt     = unit_res[SW-1:0];
        div_sh_nxt  = div_sh_r << 1;
        bit_cnt_nxt = bit_cnt_r - BW'(1);
        if (bit_cnt_r == '0) begin
          idx_nxt       = unit_res[AW-1:0];
          step_nxt      = AW'(1);
          probe_cnt_nxt = '0;
          state_nxt     = skht_pkg::S_RD;
        end
      end
      skht_pkg::S_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_r;
        if (probe_cnt_r != '0) begin
          unit_a   = UW'(step_r) + UW'(2);
          step_nxt = unit_res[AW-1:0];
        end
        state_nxt = skht_pkg::S_CMP;
      end
      skht_pkg::S_CMP: begin
        unit_a = UW'(idx_r) + UW'(step_r);
        if (hit) begin
          out_valid_nxt = 1'b1;
          state_nxt     = skht_pkg::S_IDLE;
          case (op_r)
            skht_pkg::OP_ADD: begin
              wr.en        = 1'b1;
              wr.used      = 1'b1;
              wr.addr      = idx_r;
              wr.hash      = key_r;
              out_ok_nxt   = 1'b1;
              out_slot_nxt = 8'(idx_r);
            end
            skht_pkg::OP_REMOVE: begin
              wr.en        = rd_used;
              wr.used      = 1'b0;
              wr.addr      = idx_r;
              out_ok_nxt   = rd_used;
              out_slot_nxt = rd_used ? 8'(idx_r) : 8'd0;
            end
            default: begin
              out_ok_nxt   = 1'b1;
              out_slot_nxt = 8'(idx_r);
            end
          endcase
        end else if (probe_cnt_r == size_r - SW'(1)) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b0;
          out_slot_nxt  = 8'd0;
          state_nxt     = skht_pkg::S_IDLE;
        end else begin
          idx_nxt       = unit_res[AW-1:0];
          probe_cnt_nxt = probe_cnt_r + SW'(1);
          state_nxt     = skht_pkg::S_RD;
        end
      end
      default: begin
        state_nxt = skht_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skht_pkg::S_IDLE;
      cfg_size_r  <= skht_pkg::SIZE_RESET;
      hash_r      <= skht_pkg::HASH_SEED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        cfg_size_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    size_r      <= size_nxt;
    key_r       <= key_nxt;
    op_r        <= op_nxt;
    rem_r       <= rem_nxt;
    div_sh_r    <= div_sh_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    idx_r       <= idx_nxt;
    step_r      <= step_nxt;
    probe_cnt_r <= probe_cnt_nxt;
    out_ok_r    <= out_ok_nxt;
    out_slot_r  <= out_slot_nxt;
  end

  assign busy      = (state_r != skht_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;
  assign out_slot  = out_slot_r;

endmodule

@@ sv/skht_checker.sv @@
module skht_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ok,
  input logic [7:0] out_slot
);

  a_no_slot_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_slot == 8'd0))
    else $error("slot not zero on a miss");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> ($past(start) && $past(in_last) && !$past(busy)))
    else $error("busy without a last byte");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("activity after reset");

endmodule

bind string_keyed_hash_table_top skht_checker u_skht_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_last   (in_last),
  .out_valid (out_valid),
  .out_ok    (out_ok),
  .out_slot  (out_slot)
);
